>>> rtl/eqf_pkg.sv
// Shared types and constants for the fixed-square eight queens enumerator.
`default_nettype none
package eqf_pkg;

  localparam int BoardN    = 8;
  localparam int RowW      = $clog2(BoardN);
  localparam int DiagN     = 2 * BoardN - 1;
  localparam int ColW      = $clog2(BoardN + 1);
  localparam int SolNumW   = 7;

  // One query: the square that must hold a queen, one-based.
  typedef struct packed {
    logic [3:0] queen_row;
    logic [3:0] queen_col;
  } in_t;

  // One placement: row of the queen per column, one-based.
  typedef struct packed {
    logic [3:0]         row_c1;
    logic [3:0]         row_c2;
    logic [3:0]         row_c3;
    logic [3:0]         row_c4;
    logic [3:0]         row_c5;
    logic [3:0]         row_c6;
    logic [3:0]         row_c7;
    logic [3:0]         row_c8;
    logic [SolNumW-1:0] solution_number;
    logic               last_of_run;
  } out_t;

  // Zero-based row per column, index 0 is column one.
  typedef logic [BoardN-1:0][RowW-1:0] board_t;

  // Search events from the sequencer.
  typedef struct packed {
    logic found;
    logic done;
  } evt_t;

endpackage
`default_nettype wire

>>> rtl/eqf_pick.sv
// Row picker: lowest free row at or above a start row in one column.
`default_nettype none
module eqf_pick (
  input  wire logic [eqf_pkg::RowW-1:0]    col,
  input  wire logic [eqf_pkg::ColW-1:0]    start_row,
  input  wire logic [eqf_pkg::BoardN-1:0]  rows_used,
  input  wire logic [eqf_pkg::DiagN-1:0]   diag_a,
  input  wire logic [eqf_pkg::DiagN-1:0]   diag_b,
  input  wire logic [eqf_pkg::RowW-1:0]    fix_row,
  input  wire logic [eqf_pkg::RowW-1:0]    fix_col,
  output logic                             ok,
  output logic [eqf_pkg::RowW-1:0]         row
);
  import eqf_pkg::*;

  logic [BoardN-1:0] da_w;
  logic [BoardN-1:0] db_w;
  logic [BoardN-1:0] ge_mask;
  logic [BoardN-1:0] fix_mask;
  logic [BoardN-1:0] free_w;

  // Diagonal a index is row - col + BoardN-1, diagonal b index is row + col.
  assign da_w     = BoardN'(diag_a >> (RowW'(BoardN - 1) - col));
  assign db_w     = BoardN'(diag_b >> col);
  assign ge_mask  = {BoardN{1'b1}} << start_row;
  assign fix_mask = (col == fix_col) ? (BoardN'(1) << fix_row) : {BoardN{1'b1}};
  assign free_w   = ~rows_used & ~da_w & ~db_w & ge_mask & fix_mask;

  // Priority encode, lowest row wins.
  always_comb begin
    ok  = |free_w;
    row = '0;
    for (int r = BoardN - 1; r >= 0; r--) begin
      if (free_w[r]) begin
        row = RowW'(r);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/eqf_search.sv
// Backtracking sequencer: walks the placement tree one step per cycle.
`default_nettype none
module eqf_search (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [eqf_pkg::RowW-1:0]   go_row,
  input  wire logic [eqf_pkg::RowW-1:0]   go_col,
  output eqf_pkg::evt_t                   evt,
  output eqf_pkg::board_t                 board
);
  import eqf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t              state_r,  state_nxt;
  logic [ColW-1:0]     col_r,    col_nxt;
  logic [ColW-1:0]     row_r,    row_nxt;
  board_t              place_r,  place_nxt;
  logic [BoardN-1:0]   rows_r,   rows_nxt;
  logic [DiagN-1:0]    da_r,     da_nxt;
  logic [DiagN-1:0]    db_r,     db_nxt;
  logic [RowW-1:0]     fix_row_r, fix_col_r;
  evt_t                evt_nxt;

  logic                pick_ok;
  logic [RowW-1:0]     pick_row;
  logic [RowW-1:0]     cur_col;
  logic [RowW-1:0]     prev_col;
  logic [RowW-1:0]     prev_row;

  assign cur_col  = col_r[RowW-1:0];
  assign prev_col = RowW'(col_r - ColW'(1));
  assign prev_row = place_r[prev_col];

  eqf_pick u_pick (
    .col       (cur_col),
    .start_row (row_r),
    .rows_used (rows_r),
    .diag_a    (da_r),
    .diag_b    (db_r),
    .fix_row   (fix_row_r),
    .fix_col   (fix_col_r),
    .ok        (pick_ok),
    .row       (pick_row)
  );

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    place_nxt = place_r;
    rows_nxt  = rows_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    evt_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_RUN;
          col_nxt   = '0;
          row_nxt   = '0;
          rows_nxt  = '0;
          da_nxt    = '0;
          db_nxt    = '0;
        end
      end
      S_RUN: begin
        if (col_r != ColW'(BoardN) && pick_ok) begin
          // Place a queen and advance to the next column.
          place_nxt[cur_col] = pick_row;
          rows_nxt = rows_r | (BoardN'(1) << pick_row);
          da_nxt   = da_r | (DiagN'(1) << (ColW'(pick_row) + ColW'(RowW'(BoardN - 1) - cur_col)));
          db_nxt   = db_r | (DiagN'(1) << (ColW'(pick_row) + ColW'(cur_col)));
          col_nxt  = col_r + ColW'(1);
          row_nxt  = '0;
        end else if (col_r == '0) begin
          // Column one exhausted: search complete.
          evt_nxt.done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          // Full board reached or column exhausted: retreat, reporting a full board.
          evt_nxt.found = (col_r == ColW'(BoardN));
          rows_nxt = rows_r & ~(BoardN'(1) << prev_row);
          da_nxt   = da_r & ~(DiagN'(1) << (ColW'(prev_row) + ColW'(RowW'(BoardN - 1) - prev_col)));
          db_nxt   = db_r & ~(DiagN'(1) << (ColW'(prev_row) + ColW'(prev_col)));
          col_nxt  = col_r - ColW'(1);
          row_nxt  = ColW'(prev_row) + ColW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      evt     <= '0;
    end else begin
      state_r <= state_nxt;
      evt     <= evt_nxt;
    end
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    place_r <= place_nxt;
    rows_r  <= rows_nxt;
    da_r    <= da_nxt;
    db_r    <= db_nxt;
    if (state_r == S_IDLE && go) begin
      fix_row_r <= go_row;
      fix_col_r <= go_col;
    end
  end

  // Board as it stood when the found event was raised.
  always_ff @(posedge clk) begin
    board <= place_r;
  end

endmodule
`default_nettype wire

>>> rtl/eight_queens_fixed_square_enum.sv
// Top level of the fixed-square eight queens enumerator.
//
// Channel   Direction  Handshake                      Payload
// query     in         start & !busy transfers        in_data  (eqf_pkg::in_t)
// result    out        out_valid, one-cycle strobe    out_data (eqf_pkg::out_t)
//
// A query occupies the block from its transfer until its last result is shown;
// busy stays high throughout. The sequencer takes one step per cycle: one queen
// placed, one retreat, or one retreat that also reports a full placement.
// A square off the board yields no result and leaves busy low.
// Synchronous active-low reset clears control state only.
// The receiver cannot stall: out_valid flags each result for exactly one cycle.
`default_nettype none
module eight_queens_fixed_square_enum (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire eqf_pkg::in_t    in_data,
  output logic                 busy,
  output logic                 out_valid,
  output eqf_pkg::out_t        out_data
);
  import eqf_pkg::*;

  logic              busy_r;
  logic              out_valid_r;
  out_t              out_data_r;
  out_t              hold_r;       // latest placement, waits until we know if it is last
  logic              hold_vld_r;
  logic [SolNumW-1:0] count_r;

  logic              accept;
  logic              on_board;
  logic              go;
  evt_t              evt;
  board_t            board;
  out_t              fresh;
  out_t              held_last;

  assign on_board = (in_data.queen_row >= 4'd1) && (in_data.queen_row <= 4'(BoardN)) &&
                    (in_data.queen_col >= 4'd1) && (in_data.queen_col <= 4'(BoardN));
  assign accept   = start && !busy_r;
  // Squares off the board are taken and dropped: no search, no result.
  assign go       = accept && on_board;

  eqf_search u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .go_row (RowW'(in_data.queen_row - 4'd1)),
    .go_col (RowW'(in_data.queen_col - 4'd1)),
    .evt    (evt),
    .board  (board)
  );

  // Convert the zero-based board to a one-based result record.
  always_comb begin
    fresh.row_c1          = {1'b0, board[0]} + 4'd1;
    fresh.row_c2          = {1'b0, board[1]} + 4'd1;
    fresh.row_c3          = {1'b0, board[2]} + 4'd1;
    fresh.row_c4          = {1'b0, board[3]} + 4'd1;
    fresh.row_c5          = {1'b0, board[4]} + 4'd1;
    fresh.row_c6          = {1'b0, board[5]} + 4'd1;
    fresh.row_c7          = {1'b0, board[6]} + 4'd1;
    fresh.row_c8          = {1'b0, board[7]} + 4'd1;
    fresh.solution_number = count_r + SolNumW'(1);
    fresh.last_of_run     = 1'b0;
  end

  // Held placement marked as the final one of the run.
  always_comb begin
    held_last             = hold_r;
    held_last.last_of_run = 1'b1;
  end

  // Hold each placement back until the next search event: a newer placement
  // proves the held one is not last, the done event proves it is.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hold_vld_r  <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= (evt.found || evt.done) && hold_vld_r;
      if (go) begin
        busy_r     <= 1'b1;
        hold_vld_r <= 1'b0;
        count_r    <= '0;
      end else if (evt.found) begin
        hold_vld_r <= 1'b1;
        count_r    <= count_r + SolNumW'(1);
      end else if (evt.done) begin
        busy_r     <= 1'b0;
        hold_vld_r <= 1'b0;
      end
    end
    if (evt.found) begin
      hold_r     <= fresh;
      out_data_r <= hold_r;
    end else if (evt.done) begin
      out_data_r <= held_last;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer never reports a placement and completion in the same cycle.
  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.found && evt.done))
    else $error("found and done raised together");

  // The final result of a run is shown only once the block is free again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_of_run |-> !busy_r)
    else $error("last result shown while busy");

  // A query on the board occupies the block from the next cycle.
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy_r)
    else $error("query on board did not set busy");

  // Search events only arise while a query is in progress.
  a_evt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    evt.found || evt.done |-> busy_r)
    else $error("search event while idle");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the fixed-square eight queens enumerator.
`timescale 1ns / 100ps
module testbench;
  import eqf_pkg::*;

  // Cycles to idle once nothing is expected; the block reports its last
  // placement as its final step, so only a short tail is needed.
  localparam int DrainCycles = 50;
  localparam int RandomQueries = 170;

  logic clk;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_valid;
  out_t out_data;

  // Placements still owed by the block, oldest first.
  out_t pending_placements [$];
  int   error_count = 0;

  eight_queens_fixed_square_enum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never drops busy.
  initial begin
    #50_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Enumerate every non-attacking placement holding a queen on the queried
  // square, in ascending lexicographic order of the per-column rows, and
  // append them to the pending store. Backtrack iteratively: for each column
  // keep the next row still to try, and test rows and both diagonals against
  // the queens already placed to the left.
  function automatic void enumerate_placements(input in_t q);
    int   rows_at [BoardN];
    int   next_row [BoardN];
    int   col;
    int   r;
    int   fixed_r;
    int   fixed_c;
    int   count;
    bit   clash;
    out_t sol;
    out_t batch [$];
    // A square off the board yields nothing at all.
    if (q.queen_row < 1 || q.queen_row > BoardN || q.queen_col < 1 || q.queen_col > BoardN)
      return;
    fixed_r = q.queen_row - 1;
    fixed_c = q.queen_col - 1;
    col = 0;
    next_row[0] = 0;
    count = 0;
    while (col >= 0) begin
      if (col == BoardN) begin
        count++;
        sol.row_c1 = 4'(rows_at[0] + 1);
        sol.row_c2 = 4'(rows_at[1] + 1);
        sol.row_c3 = 4'(rows_at[2] + 1);
        sol.row_c4 = 4'(rows_at[3] + 1);
        sol.row_c5 = 4'(rows_at[4] + 1);
        sol.row_c6 = 4'(rows_at[5] + 1);
        sol.row_c7 = 4'(rows_at[6] + 1);
        sol.row_c8 = 4'(rows_at[7] + 1);
        sol.solution_number = SolNumW'(count);
        sol.last_of_run = 1'b0;
        batch = {batch, sol};
        col--;
      end else if (next_row[col] == BoardN) begin
        col--;
      end else begin
        r = next_row[col];
        next_row[col]++;
        // The fixed column admits only the queried row.
        clash = (col == fixed_c) && (r != fixed_r);
        for (int k = 0; k < col; k++) begin
          if (rows_at[k] == r || rows_at[k] - r == col - k || r - rows_at[k] == col - k)
            clash = 1'b1;
        end
        if (!clash) begin
          rows_at[col] = r;
          col++;
          if (col < BoardN)
            next_row[col] = 0;
        end
      end
    end
    if (batch.size() > 0)
      batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i])
      pending_placements = {pending_placements, batch[i]};
  endfunction

  // Check every result strobe against the oldest pending placement. Values
  // are read at the edge, before the block updates them.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_placements.size() == 0) begin
        report_mismatch("unexpected result, solution_number", out_data.solution_number, 0);
      end else begin
        want = pending_placements.pop_front();
        check_field("row_c1", out_data.row_c1, want.row_c1);
        check_field("row_c2", out_data.row_c2, want.row_c2);
        check_field("row_c3", out_data.row_c3, want.row_c3);
        check_field("row_c4", out_data.row_c4, want.row_c4);
        check_field("row_c5", out_data.row_c5, want.row_c5);
        check_field("row_c6", out_data.row_c6, want.row_c6);
        check_field("row_c7", out_data.row_c7, want.row_c7);
        check_field("row_c8", out_data.row_c8, want.row_c8);
        check_field("solution_number", out_data.solution_number, want.solution_number);
        check_field("last_of_run", out_data.last_of_run, want.last_of_run);
      end
    end
  end

  // Send one query. With a gap, first drop start and wait out the gap; with
  // none, keep start high and just swap the payload, so back-to-back queries
  // never lower and raise start in the same step. Hold until the transfer
  // (start high, busy low at an edge), then predict its placements.
  task automatic send_query(input int unsigned queen_row, input int unsigned queen_col,
                            input int unsigned gap);
    in_t q;
    q.queen_row = 4'(queen_row);
    q.queen_col = 4'(queen_col);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (busy);
    enumerate_placements(q);
  endtask

  // Drop start and wait for every owed placement, then idle a short tail so
  // that any stray strobe still shows up as a failure.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Corners: fewest placements, and the extremes of both fields.
  task automatic test_corners();
    send_query(1, 1, 0);
    send_query(1, 8, 3);
    send_query(8, 1, 0);
    send_query(8, 8, 5);
    wait_for_drain();
  endtask

  // Squares off the board: no placement, and the block should stay free.
  // Mix in valid squares so the empty queries land straight after a search.
  task automatic test_off_board();
    send_query(0, 1, 1);
    send_query(1, 0, 0);
    send_query(4, 4, 0);
    send_query(9, 4, 0);
    send_query(4, 9, 2);
    send_query(15, 15, 0);
    send_query(0, 0, 0);
    send_query(5, 3, 0);
    wait_for_drain();
  endtask

  // Back-to-back queries across the middle of the board, no idling.
  task automatic test_back_to_back();
    send_query(2, 3, 0);
    send_query(5, 5, 0);
    send_query(7, 2, 0);
    send_query(3, 6, 0);
    send_query(6, 7, 0);
    send_query(4, 5, 0);
    wait_for_drain();
  endtask

  // Random squares, mostly on the board. Mix bursts without idling
  // with stretches of random gaps, and pause once mid-run until drained.
  task automatic test_random_squares();
    bit          burst;
    int unsigned gap;
    burst = 1'b0;
    for (int i = 0; i < RandomQueries; i++) begin
      if (i % 20 == 0)
        burst = ($urandom_range(0, 2) == 0);
      if (i == RandomQueries / 2)
        wait_for_drain();
      gap = burst ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 99) < 85)
        send_query($urandom_range(1, 8), $urandom_range(1, 8), gap);
      else
        send_query($urandom_range(0, 15), $urandom_range(0, 15), gap);
    end
    wait_for_drain();
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_corners();
    test_off_board();
    test_back_to_back();
    test_random_squares();

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/eqf_pkg.sv
rtl/eqf_pick.sv
rtl/eqf_search.sv
rtl/eight_queens_fixed_square_enum.sv
tb/sv/testbench.sv
